@@ rtl/iolc_pkg.sv @@
package iolc_pkg;

    // constraint kind codes carried on the action field
    typedef enum logic [2:0] {
        ACT_ADD_SUB_12 = 3'd0,
        ACT_SHIFT_32   = 3'd1,
        ACT_SHIFT_64   = 3'd2,
        ACT_LOGICAL_32 = 3'd3,
        ACT_NONE       = 3'd4
    } action_t;

    localparam int unsigned IMM_W     = 64;
    localparam int unsigned WORD_W    = 32;
    // element sizes 2, 4, 8, 16, 32
    localparam int unsigned NUM_SIZES = 5;

    // after range decode
    typedef struct packed {
        logic              simple_ok;
        logic              logical_en;
        logic [WORD_W-1:0] word;
    } rng_t;

    // after per-size pattern analysis
    typedef struct packed {
        logic                                simple_ok;
        logic                                logical_en;
        logic [NUM_SIZES-1:0]                cand;
        logic [NUM_SIZES-1:0][WORD_W-1:0]    diff;
    } pat_t;

    // element size in bits for size index lg
    function automatic int unsigned elem_size(int unsigned lg);
        elem_size = 2 << lg;
    endfunction

    // ones over the low element
    function automatic logic [WORD_W-1:0] elem_mask(int unsigned lg);
        logic [WORD_W:0] m;
        m = ({{WORD_W{1'b0}}, 1'b1} << elem_size(lg)) - {{WORD_W{1'b0}}, 1'b1};
        elem_mask = m[WORD_W-1:0];
    endfunction

    // the low element repeated across the word
    function automatic logic [WORD_W-1:0] replicate(logic [WORD_W-1:0] v, int unsigned lg);
        logic [WORD_W-1:0] r;
        logic [4:0]        sel;
        r = '0;
        for (int i = 0; i < WORD_W; i++)
        begin
            sel  = 5'(i) & 5'(elem_size(lg) - 1);
            r[i] = v[sel];
        end
        replicate = r;
    endfunction

    // boundaries of the element against itself rotated right by one
    function automatic logic [WORD_W-1:0] ring_diff(logic [WORD_W-1:0] v, int unsigned lg);
        logic [WORD_W-1:0] d;
        logic [4:0]        nxt;
        d = '0;
        for (int i = 0; i < WORD_W; i++)
        begin
            nxt = 5'(i + 1) & 5'(elem_size(lg) - 1);
            if (i < elem_size(lg))
            begin
                d[i] = v[i] ^ v[nxt];
            end
        end
        ring_diff = d;
    endfunction

endpackage

@@ rtl/iolc_range.sv @@
module iolc_range (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [2:0]                   action,
    input  logic signed [63:0]           immediate,
    output logic                         valid_reg,
    input  logic                         down_ready,
    output iolc_pkg::rng_t               data_reg
);

    iolc_pkg::rng_t data_next;
    logic           valid_next;

    // range checks per constraint kind
    always_comb
    begin
        data_next            = '0;
        data_next.word       = immediate[31:0];
        unique case (action)
            iolc_pkg::ACT_ADD_SUB_12:
            begin
                data_next.simple_ok = (immediate[63:12] == '0) ||
                                      (immediate[11:0] == '0 && immediate[63:24] == '0);
            end
            iolc_pkg::ACT_SHIFT_32:
            begin
                data_next.simple_ok = (immediate[63:5] == '0);
            end
            iolc_pkg::ACT_SHIFT_64:
            begin
                data_next.simple_ok = (immediate[63:6] == '0);
            end
            iolc_pkg::ACT_LOGICAL_32:
            begin
                data_next.logical_en = (immediate[63:32] == '0);
            end
            default:
            begin
                data_next.simple_ok = 1'b0;
            end
        endcase
    end

    assign in_ready   = !valid_reg || down_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    // stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // stage payload, loaded on transfer in
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

@@ rtl/iolc_pattern.sv @@
module iolc_pattern (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  iolc_pkg::rng_t in_data,
    output logic           valid_reg,
    input  logic           down_ready,
    output iolc_pkg::pat_t data_reg
);

    logic [iolc_pkg::NUM_SIZES-1:0]                     cand_w;
    logic [iolc_pkg::NUM_SIZES-1:0][iolc_pkg::WORD_W-1:0] diff_w;
    iolc_pkg::pat_t data_next;
    logic           valid_next;

    // per element size: periodic word with a nontrivial element
    for (genvar k = 0; k < iolc_pkg::NUM_SIZES; k++)
    begin : g_size
        logic [iolc_pkg::WORD_W-1:0] el;
        assign el        = in_data.word & iolc_pkg::elem_mask(k);
        assign cand_w[k] = (iolc_pkg::replicate(in_data.word, k) == in_data.word) &&
                           (el != '0) && (el != iolc_pkg::elem_mask(k));
        assign diff_w[k] = iolc_pkg::ring_diff(in_data.word, k);
    end

    always_comb
    begin
        data_next            = '0;
        data_next.simple_ok  = in_data.simple_ok;
        data_next.logical_en = in_data.logical_en;
        data_next.cand       = cand_w;
        data_next.diff       = diff_w;
    end

    assign in_ready   = !valid_reg || down_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    // stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

@@ rtl/iolc_verdict.sv @@
module iolc_verdict (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  iolc_pkg::pat_t in_data,
    output logic           valid_reg,
    input  logic           down_ready,
    output logic           accepted_reg
);

    logic [iolc_pkg::NUM_SIZES-1:0] two_w;
    logic                           accepted_next;
    logic                           valid_next;

    // exactly two boundaries: clear lowest set bit, remainder is a single bit
    for (genvar k = 0; k < iolc_pkg::NUM_SIZES; k++)
    begin : g_two
        logic [iolc_pkg::WORD_W-1:0] d;
        logic [iolc_pkg::WORD_W-1:0] r;
        assign d        = in_data.diff[k];
        assign r        = d & (d - {{(iolc_pkg::WORD_W-1){1'b0}}, 1'b1});
        assign two_w[k] = (r != '0) &&
                          ((r & (r - {{(iolc_pkg::WORD_W-1){1'b0}}, 1'b1})) == '0);
    end

    assign accepted_next = in_data.simple_ok ||
                           (in_data.logical_en && ((in_data.cand & two_w) != '0));

    assign in_ready   = !valid_reg || down_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            accepted_reg <= accepted_next;
        end
    end

endmodule

@@ rtl/immediate_operand_legality_check_top.sv @@
// pipeline: 3 register stages (range, pattern, verdict); out_valid is the valid bit of the
// verdict stage, and each item is registered in range, then pattern, then verdict
// throughput: one item per cycle; each stage takes a new item when empty or draining
// a stalled output holds its result while earlier stages keep filling
// reset: rst_n clears all stage valid bits asynchronously; no other state
module immediate_operand_legality_check_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         action,
    input  logic signed [63:0] immediate,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               accepted
);

    logic           rng_ready;
    logic           rng_valid;
    iolc_pkg::rng_t rng_data;
    logic           pat_ready;
    logic           pat_valid;
    iolc_pkg::pat_t pat_data;
    logic           ver_ready;

    // range decode
    iolc_range u_range (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (rng_ready),
        .action     (action),
        .immediate  (immediate),
        .valid_reg  (rng_valid),
        .down_ready (pat_ready),
        .data_reg   (rng_data)
    );

    // periodicity and boundary vectors
    iolc_pattern u_pattern (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (rng_valid),
        .in_ready   (pat_ready),
        .in_data    (rng_data),
        .valid_reg  (pat_valid),
        .down_ready (ver_ready),
        .data_reg   (pat_data)
    );

    // final decision and output register
    iolc_verdict u_verdict (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (pat_valid),
        .in_ready     (ver_ready),
        .in_data      (pat_data),
        .valid_reg    (out_valid),
        .down_ready   (!out_stall),
        .accepted_reg (accepted)
    );

    assign in_stall = !rng_ready;

endmodule
